// ===== design/spct_pkg.sv =====
package spct_pkg;

    // Command codes; any other code reads the entry
    localparam logic [1:0] CMD_ENTER = 2'd0;
    localparam logic [1:0] CMD_LEAVE = 2'd1;

    localparam logic [15:0] DEPTH_MAX = 16'hFFFF;

    // Controller states
    typedef enum logic [2:0] {
        S_CLR,   // clearing pass over the table after reset
        S_IDLE,  // waiting for start
        S_RID,   // read the named entry
        S_RB,    // named entry back, read the second entry
        S_MB,    // second entry back
        S_WB,    // write the second entry
        S_WID    // write the named entry, load the result
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic cap_in;    // latch the item
        logic out_zero;  // result for an id out of range
        logic clr_wr;    // clear one table row
        logic rd_id;     // read the named entry
        logic cap_id;    // latch named entry, read the second entry
        logic out_read;  // result for a read command
        logic cap_b;     // latch the second entry
        logic wr_b;      // write the second entry
        logic wr_id;     // write the named entry, result out
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_ok;     // id at the input is within the table
        logic cur_upd;   // latched item is an enter or a leave
        logic b_vld;     // a second entry takes part
        logic clr_last;  // clearing pass at its last row
    } t_ctrl_sts;

endpackage

// ===== design/spct_ctrl.sv =====
module spct_ctrl
    import spct_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_ctrl_sts i_sts,
    output t_ctrl_cmd o_cmd,
    output logic      o_busy
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.cap_in = 1'b1;
                    if (i_sts.in_ok) begin
                        n_state = S_RID;
                    end else begin
                        o_cmd.out_zero = 1'b1;
                    end
                end
            end
            S_RID: begin
                o_cmd.rd_id = 1'b1;
                n_state     = S_RB;
            end
            S_RB: begin
                o_cmd.cap_id = 1'b1;
                if (!i_sts.cur_upd) begin
                    o_cmd.out_read = 1'b1;
                    n_state        = S_IDLE;
                end else if (i_sts.b_vld) begin
                    n_state = S_MB;
                end else begin
                    n_state = S_WID;
                end
            end
            S_MB: begin
                o_cmd.cap_b = 1'b1;
                n_state     = S_WB;
            end
            S_WB: begin
                o_cmd.wr_b = 1'b1;
                n_state    = S_WID;
            end
            S_WID: begin
                o_cmd.wr_id = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    // A named-entry write always hands back to idle
    a_wid_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WID |=> r_state == S_IDLE)
        else $error("write of named entry not followed by idle");

    // Second entry is only written after it was read back
    a_wb_after_mb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WB |-> $past(r_state) == S_MB)
        else $error("second entry written without being read");

    // Clearing pass only leaves on its last row
    a_clr_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR && !i_sts.clr_last |=> r_state == S_CLR)
        else $error("clearing pass left early");
`endif

endmodule

// ===== design/spct_datapath.sv =====
module spct_datapath
    import spct_pkg::*;
#(
    parameter int NUM_COUNTERS = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl_cmd   i_cmd,
    output t_ctrl_sts   o_sts,
    input  logic [1:0]  i_item_cmd,
    input  logic [10:0] i_counter_id,
    input  logic [47:0] i_timestamp,
    output logic        o_valid,
    output logic [10:0] o_section_id,
    output logic [31:0] o_call_count,
    output logic [15:0] o_nest_depth,
    output logic [63:0] o_inclusive_ticks,
    output logic [63:0] o_exclusive_ticks,
    output logic        o_active_valid,
    output logic [10:0] o_active_section
);

    localparam int IDX_W = $clog2(NUM_COUNTERS);

    typedef struct packed {
        logic [31:0]      calls;
        logic [15:0]      depth;
        logic [63:0]      incl;
        logic [63:0]      excl;
        logic [47:0]      istart;
        logic [47:0]      estart;
        logic             prev_vld;
        logic [IDX_W-1:0] prev_idx;
    } t_entry;

    // Counter table
    t_entry mem [NUM_COUNTERS];
    t_entry r_rdata;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;
    logic             wr_en;

    // Item and working registers
    logic [1:0]       r_cmd;
    logic [10:0]      r_cid;
    logic [IDX_W-1:0] r_idx;
    logic [47:0]      r_now;
    t_entry           r_id_ent;
    t_entry           r_b_ent;
    logic [47:0]      r_el_id;
    logic [47:0]      r_el_inc;
    logic [47:0]      r_el_b;
    logic             r_b_vld;
    logic [IDX_W-1:0] r_b_idx;
    logic             r_same;
    logic             r_act_vld;
    logic [IDX_W-1:0] r_act_idx;
    logic [IDX_W-1:0] r_clr_addr;
    logic             r_valid;

    logic             is_enter;
    logic             is_leave;
    logic             b_vld;
    logic [IDX_W-1:0] b_idx;
    t_entry           id_new;
    t_entry           b_new;
    logic             n_act_vld;
    logic [IDX_W-1:0] n_act_idx;

    assign is_enter = (r_cmd == CMD_ENTER);
    assign is_leave = (r_cmd == CMD_LEAVE);

    // Status to the controller
    assign o_sts.in_ok    = (32'(i_counter_id) < 32'(NUM_COUNTERS));
    assign o_sts.cur_upd  = is_enter || is_leave;
    assign o_sts.b_vld    = b_vld;
    assign o_sts.clr_last = (r_clr_addr == IDX_W'(NUM_COUNTERS - 1));

    // Second entry: active section on enter, previous link on leave
    always_comb begin
        if (is_enter) begin
            b_vld = r_act_vld;
            b_idx = r_act_idx;
        end else begin
            b_vld = r_rdata.prev_vld;
            b_idx = r_rdata.prev_idx;
        end
    end

    // Table port selection
    always_comb begin
        rd_addr = i_cmd.cap_id ? b_idx : r_idx;
        wr_en   = i_cmd.clr_wr || i_cmd.wr_b || i_cmd.wr_id;
        if (i_cmd.clr_wr) begin
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else if (i_cmd.wr_b) begin
            wr_addr = r_b_idx;
            wr_data = b_new;
        end else begin
            wr_addr = r_idx;
            wr_data = id_new;
        end
    end

    // Read data only moves on the two read steps
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_id || i_cmd.cap_id) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Updated second entry
    always_comb begin
        b_new = r_b_ent;
        if (is_enter) begin
            b_new.excl = r_b_ent.excl + 64'(r_el_b);
        end else begin
            b_new.estart = r_now;
        end
    end

    // Updated named entry; when both entries coincide the second update is folded in
    always_comb begin
        id_new = r_id_ent;
        if (is_enter) begin
            id_new.calls = r_id_ent.calls + 32'd1;
            if (r_id_ent.depth != DEPTH_MAX) begin
                id_new.depth = r_id_ent.depth + 16'd1;
                if (r_id_ent.depth == 16'd0) begin
                    id_new.istart = r_now;
                end
            end
            if (r_same) begin
                id_new.excl = r_id_ent.excl + 64'(r_el_id);
            end
            id_new.estart   = r_now;
            id_new.prev_vld = r_act_vld;
            id_new.prev_idx = r_act_idx;
        end else begin
            id_new.excl = r_id_ent.excl + 64'(r_el_id);
            if (r_id_ent.depth != 16'd0) begin
                id_new.depth = r_id_ent.depth - 16'd1;
                if (r_id_ent.depth == 16'd1) begin
                    id_new.incl = r_id_ent.incl + 64'(r_el_inc);
                end
            end
            if (r_same) begin
                id_new.estart = r_now;
            end
        end
    end

    // Active section after this item
    always_comb begin
        if (is_enter) begin
            n_act_vld = 1'b1;
            n_act_idx = r_idx;
        end else begin
            n_act_vld = r_b_vld;
            n_act_idx = r_b_vld ? r_b_idx : '0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_cmd <= i_item_cmd;
            r_cid <= i_counter_id;
            r_idx <= IDX_W'(i_counter_id);
            r_now <= i_timestamp;
        end
        if (i_cmd.cap_id) begin
            r_id_ent <= r_rdata;
            r_el_id  <= r_now - r_rdata.estart;
            r_el_inc <= r_now - r_rdata.istart;
            r_b_vld  <= b_vld;
            r_b_idx  <= b_idx;
            r_same   <= b_vld && (b_idx == r_idx);
        end
        if (i_cmd.cap_b) begin
            r_b_ent <= r_rdata;
            r_el_b  <= r_now - r_rdata.estart;
        end
    end

    // Active section, clearing row and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_vld  <= 1'b0;
            r_act_idx  <= '0;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= i_cmd.out_zero || i_cmd.out_read || i_cmd.wr_id;
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (i_cmd.wr_id) begin
                r_act_vld <= n_act_vld;
                r_act_idx <= n_act_idx;
            end
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_zero) begin
            o_section_id      <= i_counter_id;
            o_call_count      <= '0;
            o_nest_depth      <= '0;
            o_inclusive_ticks <= '0;
            o_exclusive_ticks <= '0;
            o_active_valid    <= r_act_vld;
            o_active_section  <= 11'(r_act_idx);
        end else if (i_cmd.out_read) begin
            o_section_id      <= r_cid;
            o_call_count      <= r_rdata.calls;
            o_nest_depth      <= r_rdata.depth;
            o_inclusive_ticks <= r_rdata.incl;
            o_exclusive_ticks <= r_rdata.excl;
            o_active_valid    <= r_act_vld;
            o_active_section  <= 11'(r_act_idx);
        end else if (i_cmd.wr_id) begin
            o_section_id      <= r_cid;
            o_call_count      <= id_new.calls;
            o_nest_depth      <= id_new.depth;
            o_inclusive_ticks <= id_new.incl;
            o_exclusive_ticks <= id_new.excl;
            o_active_valid    <= n_act_vld;
            o_active_section  <= 11'(n_act_idx);
        end
    end

    assign o_valid = r_valid;

`ifndef SYNTHESIS
    // At most one table write source per cycle
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.clr_wr, i_cmd.wr_b, i_cmd.wr_id}))
        else $error("more than one table write in a cycle");

    // Second entry written only when one takes part
    a_wb_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_b |-> r_b_vld)
        else $error("second entry written without a link");

    // No active section reads as index zero
    a_act_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_act_vld |-> r_act_idx == '0)
        else $error("stale active index");
`endif

endmodule

// ===== design/section_profile_counter_table_unit.sv =====
// Channel   Direction  Handshake              Payload
// command   in         start & !busy          i_cmd, i_counter_id, i_timestamp
// result    out        o_valid, one cycle     o_section_id .. o_active_section
//
// Enter/leave busy: read named entry, read and write second entry (if an active
// section on enter, previous link on leave), write named entry; read: read named
// entry; id out of range: not busy. The result strobe shows in the first cycle with
// busy low again, or the cycle after acceptance for an id out of range. The single
// table memory, one read and one write per cycle, sets the steps. After reset a
// clearing pass writes one row a cycle, busy high; the receiver cannot stall.
module section_profile_counter_table_unit
    import spct_pkg::*;
#(
    parameter int NUM_COUNTERS = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [10:0] i_counter_id,
    input  logic [47:0] i_timestamp,
    output logic        o_valid,
    output logic [10:0] o_section_id,
    output logic [31:0] o_call_count,
    output logic [15:0] o_nest_depth,
    output logic [63:0] o_inclusive_ticks,
    output logic [63:0] o_exclusive_ticks,
    output logic        o_active_valid,
    output logic [10:0] o_active_section
);

    t_ctrl_cmd ctrl_cmd;
    t_ctrl_sts ctrl_sts;

    // Sequencer
    spct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (ctrl_sts),
        .o_cmd   (ctrl_cmd),
        .o_busy  (busy)
    );

    // Table and arithmetic
    spct_datapath #(
        .NUM_COUNTERS (NUM_COUNTERS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (ctrl_cmd),
        .o_sts             (ctrl_sts),
        .i_item_cmd        (i_cmd),
        .i_counter_id      (i_counter_id),
        .i_timestamp       (i_timestamp),
        .o_valid           (o_valid),
        .o_section_id      (o_section_id),
        .o_call_count      (o_call_count),
        .o_nest_depth      (o_nest_depth),
        .o_inclusive_ticks (o_inclusive_ticks),
        .o_exclusive_ticks (o_exclusive_ticks),
        .o_active_valid    (o_active_valid),
        .o_active_section  (o_active_section)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
    import spct_pkg::*;
();

    localparam int TABLE_DEPTH = 2048;
    localparam logic [1:0] CMD_READ     = 2'd2;
    localparam logic [1:0] CMD_READ_ALT = 2'd3;
    localparam int NUM_DIRECTED = 19;
    localparam int NUM_RANDOM   = 440;
    localparam int NEST_ENTERS  = 40;

    typedef struct packed {
        logic [10:0] section_id;
        logic [31:0] call_count;
        logic [15:0] nest_depth;
        logic [63:0] inclusive_ticks;
        logic [63:0] exclusive_ticks;
        logic        active_valid;
        logic [10:0] active_section;
    } t_section_report;

    typedef struct packed {
        logic [1:0]      cmd;
        logic [10:0]     id;
        logic [47:0]     ts;
        logic            typed;
        t_section_report want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_cmd = CMD_READ;
    logic [10:0] i_counter_id = '0;
    logic [47:0] i_timestamp = '0;
    logic        o_valid;
    logic [10:0] o_section_id;
    logic [31:0] o_call_count;
    logic [15:0] o_nest_depth;
    logic [63:0] o_inclusive_ticks;
    logic [63:0] o_exclusive_ticks;
    logic        o_active_valid;
    logic [10:0] o_active_section;

    // Predicted copy of the counter table
    logic [31:0] sec_calls      [TABLE_DEPTH];
    logic [15:0] sec_depth      [TABLE_DEPTH];
    logic [63:0] sec_incl       [TABLE_DEPTH];
    logic [63:0] sec_excl       [TABLE_DEPTH];
    logic [47:0] sec_incl_start [TABLE_DEPTH];
    logic [47:0] sec_excl_start [TABLE_DEPTH];
    logic [11:0] sec_prev       [TABLE_DEPTH];
    logic [11:0] cur_active;

    t_section_report pending_reports[$];
    t_stim_row       directed_rows[NUM_DIRECTED];
    logic [10:0]     id_pool[8];
    logic [10:0]     open_sections[$];
    int              err_count = 0;
    bit              quiet = 1'b0;

    section_profile_counter_table_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cmd             (i_cmd),
        .i_counter_id      (i_counter_id),
        .i_timestamp       (i_timestamp),
        .o_valid           (o_valid),
        .o_section_id      (o_section_id),
        .o_call_count      (o_call_count),
        .o_nest_depth      (o_nest_depth),
        .o_inclusive_ticks (o_inclusive_ticks),
        .o_exclusive_ticks (o_exclusive_ticks),
        .o_active_valid    (o_active_valid),
        .o_active_section  (o_active_section)
    );

    always #4 i_clk = ~i_clk;

    // Ticks since a start stamp, modulo 2^48, widened for the totals
    function automatic logic [63:0] ticks_since(input logic [47:0] now, input logic [47:0] from);
        logic [47:0] d;
        d = now - from;
        return {16'd0, d};
    endfunction

    // Apply one item to the predicted table and build its report
    function automatic t_section_report profile_event(input logic [1:0] c,
                                                      input logic [10:0] id,
                                                      input logic [47:0] now);
        t_section_report r;
        logic [10:0] a;
        bit ok;
        ok = int'(id) < TABLE_DEPTH;
        r = '0;
        if (ok && c == CMD_ENTER) begin
            sec_calls[id] = sec_calls[id] + 32'd1;
            if (sec_depth[id] != DEPTH_MAX) begin
                sec_depth[id] = sec_depth[id] + 16'd1;
                if (sec_depth[id] == 16'd1) sec_incl_start[id] = now;
            end
            if (cur_active != 12'd0) begin
                a = 11'(cur_active - 12'd1);
                sec_excl[a] = sec_excl[a] + ticks_since(now, sec_excl_start[a]);
            end
            sec_prev[id] = cur_active;
            sec_excl_start[id] = now;
            cur_active = {1'b0, id} + 12'd1;
        end else if (ok && c == CMD_LEAVE) begin
            sec_excl[id] = sec_excl[id] + ticks_since(now, sec_excl_start[id]);
            if (sec_depth[id] != 16'd0) begin
                sec_depth[id] = sec_depth[id] - 16'd1;
                if (sec_depth[id] == 16'd0)
                    sec_incl[id] = sec_incl[id] + ticks_since(now, sec_incl_start[id]);
            end
            cur_active = sec_prev[id];
            if (cur_active != 12'd0) sec_excl_start[11'(cur_active - 12'd1)] = now;
        end
        r.section_id = id;
        if (ok) begin
            r.call_count      = sec_calls[id];
            r.nest_depth      = sec_depth[id];
            r.inclusive_ticks = sec_incl[id];
            r.exclusive_ticks = sec_excl[id];
        end
        r.active_valid   = (cur_active != 12'd0);
        r.active_section = (cur_active != 12'd0) ? 11'(cur_active - 12'd1) : 11'd0;
        return r;
    endfunction

    // Present one item, wait for it to be taken, then queue its report
    task automatic issue_item(input logic [1:0] c, input logic [10:0] id,
                              input logic [47:0] ts, input logic typed,
                              input t_section_report want);
        int gap;
        t_section_report predicted;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < 11) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_cmd        <= c;
        i_counter_id <= id;
        i_timestamp  <= ts;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = profile_event(c, id, ts);
        pending_reports.insert(pending_reports.size(), typed ? want : predicted);
    endtask

    // Result checker: every strobe against the oldest expectation
    always @(posedge i_clk) begin
        t_section_report exp_r;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_reports.size() == 0) begin
                $error("result for section %0d with no item outstanding", o_section_id);
                err_count++;
            end else begin
                exp_r = pending_reports.pop_front();
                if (o_section_id !== exp_r.section_id) begin
                    $error("section_id: expected %0d, got %0d", exp_r.section_id, o_section_id);
                    err_count++;
                end
                if (o_call_count !== exp_r.call_count) begin
                    $error("call_count: expected %0d, got %0d", exp_r.call_count, o_call_count);
                    err_count++;
                end
                if (o_nest_depth !== exp_r.nest_depth) begin
                    $error("nest_depth: expected %0d, got %0d", exp_r.nest_depth, o_nest_depth);
                    err_count++;
                end
                if (o_inclusive_ticks !== exp_r.inclusive_ticks) begin
                    $error("inclusive_ticks: expected %h, got %h",
                           exp_r.inclusive_ticks, o_inclusive_ticks);
                    err_count++;
                end
                if (o_exclusive_ticks !== exp_r.exclusive_ticks) begin
                    $error("exclusive_ticks: expected %h, got %h",
                           exp_r.exclusive_ticks, o_exclusive_ticks);
                    err_count++;
                end
                if (o_active_valid !== exp_r.active_valid) begin
                    $error("active_valid: expected %0d, got %0d",
                           exp_r.active_valid, o_active_valid);
                    err_count++;
                end
                if (o_active_section !== exp_r.active_section) begin
                    $error("active_section: expected %0d, got %0d",
                           exp_r.active_section, o_active_section);
                    err_count++;
                end
            end
        end
    end

    // Watchdog, well beyond the slowest correct run
    initial begin
        #(64'd40_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int roll;
        logic [47:0] ts_now;
        logic [10:0] pick;
        logic [1:0]  c;

        for (int k = 0; k < TABLE_DEPTH; k++) begin
            sec_calls[k] = '0;
            sec_depth[k] = '0;
            sec_incl[k] = '0;
            sec_excl[k] = '0;
            sec_incl_start[k] = '0;
            sec_excl_start[k] = '0;
            sec_prev[k] = '0;
        end
        cur_active = '0;

        // Directed table: extremes, re-entry, leave at depth zero, non-active leave, wrap
        directed_rows[0]  = '{CMD_READ,     11'd0,    48'd0, 1'b1,
                              '{11'd0, 32'd0, 16'd0, 64'd0, 64'd0, 1'b0, 11'd0}};
        directed_rows[1]  = '{CMD_READ_ALT, 11'd2047, 48'hFFFF_FFFF_FFFF, 1'b1,
                              '{11'd2047, 32'd0, 16'd0, 64'd0, 64'd0, 1'b0, 11'd0}};
        directed_rows[2]  = '{CMD_LEAVE,    11'd5,    48'd100, 1'b1,
                              '{11'd5, 32'd0, 16'd0, 64'd0, 64'd100, 1'b0, 11'd0}};
        directed_rows[3]  = '{CMD_ENTER,    11'd2047, 48'hFFFF_FFFF_FFF0, 1'b1,
                              '{11'd2047, 32'd1, 16'd1, 64'd0, 64'd0, 1'b1, 11'd2047}};
        directed_rows[4]  = '{CMD_ENTER,    11'd0,    48'h10, 1'b0, '0};
        directed_rows[5]  = '{CMD_ENTER,    11'd0,    48'h20, 1'b0, '0};
        directed_rows[6]  = '{CMD_LEAVE,    11'd0,    48'h30, 1'b0, '0};
        directed_rows[7]  = '{CMD_LEAVE,    11'd0,    48'h40, 1'b0, '0};
        directed_rows[8]  = '{CMD_LEAVE,    11'd2047, 48'h50, 1'b0, '0};
        directed_rows[9]  = '{CMD_ENTER,    11'd1024, 48'hFFFF_FFFF_FFFF, 1'b0, '0};
        directed_rows[10] = '{CMD_ENTER,    11'd3,    48'd0, 1'b0, '0};
        directed_rows[11] = '{CMD_LEAVE,    11'd1024, 48'd5, 1'b0, '0};
        directed_rows[12] = '{CMD_LEAVE,    11'd3,    48'd9, 1'b0, '0};
        directed_rows[13] = '{CMD_READ,     11'd1024, 48'd10, 1'b0, '0};
        directed_rows[14] = '{CMD_LEAVE,    11'd1024, 48'd20, 1'b0, '0};
        directed_rows[15] = '{CMD_READ_ALT, 11'd3,    48'd21, 1'b0, '0};
        directed_rows[16] = '{CMD_ENTER,    11'd1,    48'h1234_5678_9ABC, 1'b0, '0};
        directed_rows[17] = '{CMD_LEAVE,    11'd1,    48'h1234_5678_9ABB, 1'b0, '0};
        directed_rows[18] = '{CMD_READ,     11'd1,    48'h5555_5555_5555, 1'b0, '0};

        for (int k = 0; k < 8; k++) id_pool[k] = 11'($urandom());
        id_pool[0] = 11'd0;
        id_pool[1] = 11'd2047;

        // Reset; the clearing pass then holds busy high
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < NUM_DIRECTED; k++)
            issue_item(directed_rows[k].cmd, directed_rows[k].id, directed_rows[k].ts,
                       directed_rows[k].typed, directed_rows[k].want);

        // Deep nesting: one section entered over and over, no gaps
        quiet = 1'b1;
        ts_now = 48'hFFFF_FFFF_FFE0;
        for (int k = 0; k < NEST_ENTERS; k++) begin
            issue_item(CMD_ENTER, 11'd7, ts_now, 1'b0, '0);
            ts_now = ts_now + 48'd1;
        end
        issue_item(CMD_ENTER, 11'd7, ts_now, 1'b0, '0);
        issue_item(CMD_LEAVE, 11'd7, ts_now + 48'd3, 1'b0, '0);
        issue_item(CMD_READ, 11'd7, ts_now + 48'd4, 1'b0, '0);
        quiet = 1'b0;

        // Random part: mostly nested enter/leave sequences, some noise
        for (int n = 0; n < NUM_RANDOM; n++) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 5) ts_now = 48'({$urandom(), $urandom()});
            else ts_now = ts_now + 48'($urandom_range(0, 4000));
            pick = id_pool[$urandom_range(0, 7)];
            if (roll < 8) begin
                issue_item(2'($urandom()), 11'($urandom()), 48'({$urandom(), $urandom()}),
                           1'b0, '0);
            end else if (roll < 45 && open_sections.size() < 12) begin
                open_sections.insert(open_sections.size(), pick);
                issue_item(CMD_ENTER, pick, ts_now, 1'b0, '0);
            end else if (roll < 80 && open_sections.size() > 0) begin
                issue_item(CMD_LEAVE, open_sections.pop_back(), ts_now, 1'b0, '0);
            end else if (roll < 86) begin
                issue_item(CMD_LEAVE, pick, ts_now, 1'b0, '0);
            end else begin
                c = $urandom_range(0, 1) ? CMD_READ : CMD_READ_ALT;
                issue_item(c, pick, ts_now, 1'b0, '0);
            end
        end
        start <= 1'b0;

        // Drain outstanding reports, then a short settle
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/spct_pkg.sv
design/spct_ctrl.sv
design/spct_datapath.sv
design/section_profile_counter_table_unit.sv
test/tb_top.sv
